// ----- design/sorted_key_value_table_top_macros.svh -----
// Assertion macros for the sorted key-value table checker.
// Clocked on clock, held off during reset; used by the checker file only.
`ifndef SORTED_KEY_VALUE_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define SKV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted key-value table check failed");

// next-cycle implication
`define SKV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted key-value table check failed");

`endif

// ----- design/skv_pkg.sv -----
// Shared types and constants for the sorted key-value table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package skv_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_KEY_WIDTH   = 32;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int FIELD_W         = 32;

   typedef enum logic [0:0] {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_HIT     = 3'd0,
      STAT_MISS    = 3'd1,
      STAT_UPDATED = 3'd2,
      STAT_ADDED   = 3'd3,
      STAT_DROPPED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_FINISH
   } fsm_type;

   // search token walking down the cell row
   typedef struct packed {
      logic live;
      logic done;
      logic hit;
   } tok_ctl_type;

   // table write command broadcast to every cell
   typedef struct packed {
      logic upd;
      logic add;
   } cmd_type;

endpackage

// ----- design/sorted_key_value_table_top.sv -----
// Top level of the sorted key-value table: request capture, control FSM,
// row of skv_cell entries and response register. Depends on skv_pkg, skv_cell.
//
//   channel | direction | tuser          | tdata
//   req_    | in        | [0] opcode     | [31:0] key, [63:32] value
//   rsp_    | out       | [2:0] status   | [31:0] found_value
//
// One request at a time; the search token steps one cell per cycle along the row,
// the response is loaded once the token has left the last cell and the response
// register is free, and the next request is taken after that load.
// Writes to the table (update or shifted insert) happen together with that load.
// The next request is taken while a response still waits in its register.
// Reset is synchronous and empties the table (entry count to zero).
`timescale 1ns / 1ps

module sorted_key_value_table_top
   import skv_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] opcode
   input  logic [63:0] req_tdata,   // [31:0] key, [63:32] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic [31:0] rsp_tdata    // [31:0] found_value
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   fsm_type                state_ff, state_in;
   opcode_type             op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic                   launch_ff, launch_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   res_hit_ff;
   logic [VALUE_WIDTH-1:0] res_val_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]     rsp_found_ff, rsp_found_in;

   logic                   accept;
   logic                   rsp_load;
   logic                   not_full;
   cmd_type                cmd;

   logic                   lt_vec      [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0]   key_vec     [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] val_vec     [TABLE_DEPTH];
   tok_ctl_type            tok_vec     [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] tok_val_vec [TABLE_DEPTH];
   tok_ctl_type            tok_head;

   assign req_tready = (state_ff == FSM_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign not_full   = (count_ff < CNT_W'(TABLE_DEPTH));
   assign tok_head   = '{live: launch_ff, done: 1'b0, hit: 1'b0};

   // request capture and search result capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= opcode_type'(req_tuser[0]);
         key_ff   <= KEY_WIDTH'(req_tdata[31:0]);
         value_ff <= VALUE_WIDTH'(req_tdata[63:32]);
      end
      if (tok_vec[TABLE_DEPTH-1].live) begin
         res_hit_ff <= tok_vec[TABLE_DEPTH-1].hit;
         res_val_ff <= tok_val_vec[TABLE_DEPTH-1];
      end
   end

   generate
      for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         logic                   prev_lt;
         logic [KEY_WIDTH-1:0]   prev_key;
         logic [VALUE_WIDTH-1:0] prev_value;
         tok_ctl_type            prev_tok;
         logic [VALUE_WIDTH-1:0] prev_tok_val;

         if (i == 0) begin : g_head
            // below the first cell sits a virtual key smaller than any other
            assign prev_lt      = 1'b1;
            assign prev_key     = '0;
            assign prev_value   = '0;
            assign prev_tok     = tok_head;
            assign prev_tok_val = '0;
         end else begin : g_link
            assign prev_lt      = lt_vec[i-1];
            assign prev_key     = key_vec[i-1];
            assign prev_value   = val_vec[i-1];
            assign prev_tok     = tok_vec[i-1];
            assign prev_tok_val = tok_val_vec[i-1];
         end

         skv_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cell_valid  (count_ff > CNT_W'(i)),
            .req_key     (key_ff),
            .req_value   (value_ff),
            .cmd         (cmd),
            .prev_lt     (prev_lt),
            .prev_key    (prev_key),
            .prev_value  (prev_value),
            .tok_in      (prev_tok),
            .tok_val_in  (prev_tok_val),
            .lt          (lt_vec[i]),
            .key_out     (key_vec[i]),
            .value_out   (val_vec[i]),
            .tok_out     (tok_vec[i]),
            .tok_val_out (tok_val_vec[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         launch_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      launch_in     = 1'b0;
      count_in      = count_ff;
      rsp_load      = 1'b0;
      cmd           = '0;
      rsp_status_in = STAT_MISS;
      rsp_found_in  = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      case (op_ff)
         OP_LOOKUP: begin
            rsp_status_in = res_hit_ff ? STAT_HIT : STAT_MISS;
            rsp_found_in  = res_hit_ff ? FIELD_W'(res_val_ff) : '0;
         end
         OP_INSERT: begin
            if (res_hit_ff) begin
               rsp_status_in = STAT_UPDATED;
            end else if (not_full) begin
               rsp_status_in = STAT_ADDED;
            end else begin
               rsp_status_in = STAT_DROPPED;
            end
         end
         default: begin
            rsp_status_in = STAT_MISS;
         end
      endcase

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               launch_in = 1'b1;
               state_in  = FSM_WALK;
            end
         end
         FSM_WALK: begin
            if (tok_vec[TABLE_DEPTH-1].live) begin
               state_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               cmd.upd      = (op_ff == OP_INSERT) && res_hit_ff;
               cmd.add      = (op_ff == OP_INSERT) && !res_hit_ff && not_full;
               if (cmd.add) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_found_ff;

endmodule

// ----- design/skv_cell.sv -----
// One table entry: key and value registers, compare against the request key,
// token stage for the search walk. Depends on skv_pkg.
`timescale 1ns / 1ps

module skv_cell
   import skv_pkg::*;
#(
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cell_valid,
   input  logic [KEY_WIDTH-1:0]   req_key,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  cmd_type                cmd,
   input  logic                   prev_lt,
   input  logic [KEY_WIDTH-1:0]   prev_key,
   input  logic [VALUE_WIDTH-1:0] prev_value,
   input  tok_ctl_type            tok_in,
   input  logic [VALUE_WIDTH-1:0] tok_val_in,
   output logic                   lt,
   output logic [KEY_WIDTH-1:0]   key_out,
   output logic [VALUE_WIDTH-1:0] value_out,
   output tok_ctl_type            tok_out,
   output logic [VALUE_WIDTH-1:0] tok_val_out
);

   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   tok_ctl_type            tok_ff, tok_in_nx;
   logic [VALUE_WIDTH-1:0] tok_val_ff, tok_val_in_nx;
   logic                   eq;

   assign lt = cell_valid && (key_ff < req_key);
   assign eq = cell_valid && (key_ff == req_key);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.add && !lt) begin
         // first cell at or above the new key takes it, the rest shift up
         if (prev_lt) begin
            key_in   = req_key;
            value_in = req_value;
         end else begin
            key_in   = prev_key;
            value_in = prev_value;
         end
      end else if (cmd.upd && eq) begin
         value_in = req_value;
      end
   end

   always_comb begin
      tok_in_nx     = tok_in;
      tok_val_in_nx = tok_val_in;
      if (tok_in.live && !tok_in.done && !lt) begin
         // sorted order: the first cell not below the key decides
         tok_in_nx.done = 1'b1;
         tok_in_nx.hit  = eq;
         tok_val_in_nx  = eq ? value_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      value_ff   <= value_in;
      tok_val_ff <= tok_val_in_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nx;
      end
   end

   assign key_out     = key_ff;
   assign value_out   = value_ff;
   assign tok_out     = tok_ff;
   assign tok_val_out = tok_val_ff;

endmodule

// ----- design/skv_checker.sv -----
// Port-level checks for the sorted key-value table, bound to the top level.
// Depends on skv_pkg and sorted_key_value_table_top_macros.svh.
`timescale 1ns / 1ps
`include "sorted_key_value_table_top_macros.svh"

module skv_checker
   import skv_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser,
   input logic [31:0] rsp_tdata
);

   logic req_take;
   logic rsp_hold;

   assign req_take = req_tvalid && req_tready;
   assign rsp_hold = rsp_tvalid && !rsp_tready;

   // a stalled response keeps its contents
   `SKV_ASSERT_NEXT(a_rsp_hold, rsp_hold, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // only a lookup hit carries a value
   `SKV_ASSERT_NOW(a_found_zero, rsp_tvalid && (rsp_tuser != STAT_HIT), rsp_tdata == '0)
   // status codes stay within the defined set
   `SKV_ASSERT_NOW(a_status_range, rsp_tvalid, rsp_tuser <= STAT_DROPPED)
   // one request in flight: no second accept right behind the first
   `SKV_ASSERT_NEXT(a_one_at_a_time, req_take, !req_tready)
   // the search walk means no response straight after an accept
   `SKV_ASSERT_NEXT(a_no_instant_rsp, req_take, !$rose(rsp_tvalid))

endmodule

bind sorted_key_value_table_top skv_checker u_skv_checker (.*);

// ----- tb/tb.sv -----
// Self-checking bench for sorted_key_value_table_top: lookups and inserts in
// four pacing phases, every response checked against an in-bench copy of the
// table. Depends on skv_pkg and the design files only.
`timescale 1ns / 1ps

module tb;
   import skv_pkg::*;

   localparam int ROW_DEPTH      = DEF_TABLE_DEPTH;
   localparam int ITEMS_PER_PASS = 500;
   localparam int STALL_LIMIT    = 20000;
   localparam int HOLD_OFF_LEN   = 3000;

   // Mirror of the table contents; predicts each response as its request is taken.
   class kv_table_scoreboard;
      typedef struct packed {
         status_type  status;
         logic [31:0] value;
      } reply_type;

      logic [31:0] keys [ROW_DEPTH];
      logic [31:0] values [ROW_DEPTH];
      int unsigned fill;
      reply_type   awaited_replies [$];
      int unsigned errors;
      int unsigned tally [5];

      function int unsigned lower_bound(logic [31:0] key);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = fill;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (keys[mid] < key) lo = mid + 1;
            else hi = mid;
         end
         return lo;
      endfunction

      function void note_request(opcode_type op, logic [31:0] key, logic [31:0] value);
         int unsigned pos;
         bit          hit;
         reply_type   rep;
         pos = lower_bound(key);
         hit = (pos < fill) && (keys[pos] == key);
         rep.value = '0;
         if (op == OP_LOOKUP) begin
            if (hit) begin
               rep.status = STAT_HIT;
               rep.value  = values[pos];
            end else begin
               rep.status = STAT_MISS;
            end
         end else if (hit) begin
            values[pos] = value;
            rep.status  = STAT_UPDATED;
         end else if (fill >= ROW_DEPTH) begin
            rep.status = STAT_DROPPED;
         end else begin
            // open a slot: shift the larger keys up by one
            for (int i = fill; i > pos; i--) begin
               keys[i]   = keys[i - 1];
               values[i] = values[i - 1];
            end
            keys[pos]   = key;
            values[pos] = value;
            fill++;
            rep.status = STAT_ADDED;
         end
         tally[rep.status]++;
         awaited_replies.push_back(rep);
      endfunction

      function void check_response(logic [2:0] status, logic [31:0] found);
         reply_type want;
         if (awaited_replies.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding: status %0d value 0x%08h",
                     $time, status, found);
            return;
         end
         want = awaited_replies.pop_front();
         if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         end
         if (found !== want.value) begin
            errors++;
            $display("%0t: found_value expected 0x%08h actual 0x%08h",
                     $time, want.value, found);
         end
      endfunction

      function logic [31:0] stored_key();
         return keys[$urandom_range(fill - 1)];
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [0:0]  req_tuser  = '0;   // [0] opcode
   logic [63:0] req_tdata  = '0;   // [31:0] key, [63:32] value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;         // [2:0] status
   logic [31:0] rsp_tdata;         // [31:0] found_value

   kv_table_scoreboard table_sb = new;
   int unsigned sender_idle_pct = 0;
   int unsigned rsp_stall_pct   = 0;
   int unsigned hold_off_cycles = 0;
   int unsigned quiet_cycles    = 0;
   int unsigned request_count   = 0;

   sorted_key_value_table_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Note requests, check responses and watch for a hung block.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            table_sb.note_request(opcode_type'(req_tuser[0]), req_tdata[31:0],
                                  req_tdata[63:32]);
            request_count++;
         end
         if (rsp_tvalid && rsp_tready) table_sb.check_response(rsp_tuser, rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   // Response side: random stalls, occasional long ones, and the requested hold-off.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (rsp_stall_pct != 0 && $urandom_range(49) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(20, 400)) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
            @(posedge clock);
         end
      end
   end

   task automatic send_request(opcode_type op, logic [31:0] key, logic [31:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, key};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         if ($urandom_range(9) == 0) repeat ($urandom_range(20, 300)) @(posedge clock);
         else repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (table_sb.awaited_replies.size() != 0) @(posedge clock);
   endtask

   // Mostly keys already held or next to one, so hits, updates and shifts are common.
   task automatic random_request();
      opcode_type  op;
      logic [31:0] key;
      logic [31:0] value;
      int unsigned pick;
      op   = ($urandom_range(99) < 60) ? OP_INSERT : OP_LOOKUP;
      pick = $urandom_range(99);
      if (pick < 40 && table_sb.fill != 0) key = table_sb.stored_key();
      else if (pick < 60 && table_sb.fill != 0)
         key = table_sb.stored_key() + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
      else if (pick < 65) key = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
      else key = $urandom;
      case ($urandom_range(9))
         0: value = 32'h0;
         1: value = 32'hFFFF_FFFF;
         default: value = $urandom;
      endcase
      send_request(op, key, value);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, edge keys, front/back/middle inserts, update, near misses
      send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
      send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
      send_request(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h8000_0001, 32'h0000_0000);
      send_request(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
      send_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      send_request(OP_INSERT, 32'h0000_0001, 32'h0000_0001);
      send_request(OP_INSERT, 32'hFFFF_FFFE, 32'h8000_0000);
      send_request(OP_LOOKUP, 32'hFFFF_FFFD, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000);
      wait_drained();

      for (int pass = 0; pass < 4; pass++) begin
         case (pass)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin sender_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         for (int n = 0; n < ITEMS_PER_PASS; n++) begin
            // hold the response side off while requests keep coming
            if (pass == 0 && n == 100) hold_off_cycles = HOLD_OFF_LEN;
            if (pass == 1 && n == 250) wait_drained();
            random_request();
            sender_gap();
         end
         wait_drained();
      end

      repeat (ROW_DEPTH + 8) @(posedge clock);
      $display("Ran %0d requests: %0d hits, %0d misses, %0d updates, %0d adds, %0d drops",
               request_count, table_sb.tally[STAT_HIT], table_sb.tally[STAT_MISS],
               table_sb.tally[STAT_UPDATED], table_sb.tally[STAT_ADDED],
               table_sb.tally[STAT_DROPPED]);
      $display("Table ended with %0d of %0d entries in use", table_sb.fill, ROW_DEPTH);
      if (table_sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
